/* design/alpe_pkg.sv */
`default_nettype none

package alpe_pkg;

	// Width of the word that is shifted out on the line, 24 bits.
	localparam int COLOR_BITS = 24;
	// Fixed widths of the request and register fields.
	localparam int COLOR_W = 24;
	localparam int TICK_W = 12;
	localparam int SLOT_W = 9;
	localparam int CFG_W = 12;
	localparam int RSLOT_W = 8;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 2'd3;

	// Register values after reset.
	localparam logic [TICK_W-1:0] SLOT_PERIOD_RST = 12'd180;
	localparam logic [TICK_W-1:0] HIGH_ZERO_RST = 12'd50;
	localparam logic [TICK_W-1:0] HIGH_ONE_RST = 12'd101;
	localparam logic [RSLOT_W-1:0] RESET_SLOTS_RST = 8'd48;

	typedef logic [COLOR_BITS-1:0] word_t;

	// Kind of an input request, as decoded by the front end.
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_COLOR = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t kind;
		logic [COLOR_W-1:0] color;
	} item_t;

	// Link from the front-end queue to the engine.
	typedef struct packed {
		logic valid;
		item_t item;
	} qlink_t;

endpackage

`default_nettype wire

/* design/alpe_in_if.sv */
`default_nettype none

interface alpe_in_if;
	import alpe_pkg::*;

	logic valid;
	logic ready;
	logic command;
	logic [COLOR_W-1:0] color;

	modport source (output valid, output command, output color, input ready);
	modport sink (input valid, input command, input color, output ready);
endinterface

`default_nettype wire

/* design/alpe_out_if.sv */
`default_nettype none

interface alpe_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;

	modport source (output valid, output line_level, output busy_res, input ready);
	modport sink (input valid, input line_level, input busy_res, output ready);
endinterface

`default_nettype wire

/* design/alpe_front.sv */
`default_nettype none

module alpe_front (
	input wire logic clk,
	input wire logic arst_n,
	alpe_in_if.sink in_ch,
	output alpe_pkg::qlink_t q_out,
	input wire logic q_pop
);
	import alpe_pkg::*;

	item_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	item_t item_in;

	// Decode the command into a request kind.
	always_comb begin
		item_in.kind = in_ch.command ? CMD_COLOR : CMD_TICK;
		item_in.color = in_ch.color;
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;

	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item = entry_q[rd_ptr_q];

	// Two-entry queue between the front end and the engine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0)
		else $error("pop from an empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* design/alpe_back.sv */
`default_nettype none

module alpe_back (
	input wire logic clk,
	input wire logic arst_n,
	input alpe_pkg::qlink_t q_in,
	output logic q_pop,
	alpe_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [alpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [alpe_pkg::CFG_W-1:0] cfg_wdata
);
	import alpe_pkg::*;

	// Configuration registers.
	logic [TICK_W-1:0] slot_period_q;
	logic [TICK_W-1:0] high_zero_q;
	logic [TICK_W-1:0] high_one_q;
	logic [RSLOT_W-1:0] reset_slots_q;

	// Encoder state.
	logic [COLOR_W-1:0] pend_color_q;
	logic pend_valid_q;
	word_t shift_q;
	logic [TICK_W-1:0] tick_q;
	logic [SLOT_W-1:0] slot_q;
	logic sending_q;
	logic line_q;

	// Output register.
	logic out_valid_q;
	logic out_line_q;
	logic out_busy_q;

	logic is_tick;
	logic starting;
	logic snd;
	word_t sw;
	logic [TICK_W-1:0] tis;
	logic [SLOT_W-1:0] sn;
	logic [SLOT_W-1:0] sn_next;
	logic in_data;
	logic [TICK_W-1:0] high;
	logic level;
	logic slot_end;
	logic frame_end;

	assign q_pop = q_in.valid && (!out_valid_q || out_ch.ready);
	assign is_tick = (q_in.item.kind == CMD_TICK);

	// A tick on an idle encoder with a pending color starts the frame on that tick.
	always_comb begin
		starting = !sending_q && pend_valid_q;
		snd = sending_q || starting;
		sw = starting ? word_t'(pend_color_q) : shift_q;
		tis = starting ? '0 : tick_q;
		sn = starting ? '0 : slot_q;
		in_data = (sn < SLOT_W'(COLOR_BITS));
		high = sw[COLOR_BITS-1] ? high_one_q : high_zero_q;
		level = snd && in_data && (tis < high);
		slot_end = (({1'b0, tis} + 13'd1) >= {1'b0, slot_period_q});
		sn_next = sn + 9'd1;
		frame_end = ({1'b0, sn_next} >= (10'(COLOR_BITS) + {2'b00, reset_slots_q}));
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_period_q <= SLOT_PERIOD_RST;
			high_zero_q <= HIGH_ZERO_RST;
			high_one_q <= HIGH_ONE_RST;
			reset_slots_q <= RESET_SLOTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_PERIOD: slot_period_q <= cfg_wdata;
				REG_HIGH_ZERO: high_zero_q <= cfg_wdata;
				REG_HIGH_ONE: high_one_q <= cfg_wdata;
				REG_RESET_SLOTS: reset_slots_q <= cfg_wdata[RSLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Encoder state update and result capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_color_q <= '0;
			pend_valid_q <= 1'b0;
			shift_q <= '0;
			tick_q <= '0;
			slot_q <= '0;
			sending_q <= 1'b0;
			line_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_line_q <= 1'b0;
			out_busy_q <= 1'b0;
		end else begin
			out_valid_q <= q_pop || (out_valid_q && !out_ch.ready);
			if (q_pop) begin
				if (!is_tick) begin
					pend_color_q <= q_in.item.color;
					pend_valid_q <= 1'b1;
					out_line_q <= line_q;
					out_busy_q <= sending_q;
				end else begin
					out_line_q <= level;
					out_busy_q <= snd;
					line_q <= level;
					if (starting) begin
						pend_valid_q <= 1'b0;
					end
					if (snd) begin
						if (slot_end) begin
							tick_q <= '0;
							shift_q <= in_data ? (sw << 1) : sw;
							if (frame_end) begin
								sending_q <= 1'b0;
								slot_q <= '0;
							end else begin
								sending_q <= 1'b1;
								slot_q <= sn_next;
							end
						end else begin
							tick_q <= tis + 12'd1;
							shift_q <= sw;
							slot_q <= sn;
							sending_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.line_level = out_line_q;
	assign out_ch.busy_res = out_busy_q;

	a_idle_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (tick_q == '0 && slot_q == '0))
		else $error("slot counters not cleared while idle");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && is_tick && starting) |=> (sending_q && !pend_valid_q && out_busy_q))
		else $error("frame did not start on a pending color");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && is_tick && !sending_q && !pend_valid_q) |=> (!out_line_q && !out_busy_q))
		else $error("idle tick drove the line");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable({out_line_q, out_busy_q})))
		else $error("result changed while the receiver stalled");

endmodule

`default_nettype wire

/* design/addressable_led_pulse_encoder_top.sv */
// Pulse encoder for a single-wire addressable LED data line.
// Input channel in_ch: each request is either a timer tick (command 0) or a
// new GRB color (command 1, color[23:16] green, [15:8] red, [7:0] blue).
// Output channel out_ch: exactly one result per request, in order, giving
// line_level (the data line after that request) and busy_res.
// A color request replaces any pending color not yet started; the next tick
// on an idle encoder starts the frame: 24 bit slots MSB first, then
// reset_slots low slots. Timing registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the
// encoder is idle, which the block itself does not enforce.
// A result passes through the front-end queue and then the engine's
// output register before it can be taken.
// Throughput: one request per cycle while the receiver takes the results.
// Reset clears the queue, the pending color and the frame state, drives the
// line low and loads the default timing (180, 50, 101, 48).
// When the receiver stalls, the output register holds its result, the
// two-entry queue fills and in_ch.ready drops until results are taken.
`default_nettype none

module addressable_led_pulse_encoder_top (
	input wire logic clk,
	input wire logic arst_n,
	alpe_in_if.sink in_ch,
	alpe_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [alpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [alpe_pkg::CFG_W-1:0] cfg_wdata
);
	import alpe_pkg::*;

	qlink_t q_link;
	logic q_pop;

	// Front end: accept and decode requests into the queue.
	alpe_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_ch (in_ch),
		.q_out (q_link),
		.q_pop (q_pop)
	);

	// Engine: pulse timing, state update and output register.
	alpe_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_in (q_link),
		.q_pop (q_pop),
		.out_ch (out_ch),
		.cfg_we (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule

`default_nettype wire

/* tb/sv/addressable_led_pulse_encoder_top_tb.sv */
`timescale 1ns / 100ps

module addressable_led_pulse_encoder_top_tb;
	import alpe_pkg::*;

	// A result leaves the encoder through the front-end queue and the output register.
	localparam int PIPE_LATENCY = 2;
	localparam int LONG_STALL = 300;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 40;
	localparam int DIRECTED_ROWS = 24;

	typedef struct packed {
		logic level;
		logic busy;
	} line_out_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_TIMING
	} row_kind_t;

	// One row of the directed table: a request, or a new set of timing registers.
	typedef struct packed {
		row_kind_t kind;
		cmd_t cmd;
		logic [COLOR_W-1:0] color;
		logic known;
		logic exp_level;
		logic exp_busy;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] hi_zero;
		logic [TICK_W-1:0] hi_one;
		logic [RSLOT_W-1:0] latch;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	alpe_in_if in_ch ();
	alpe_out_if out_ch ();

	addressable_led_pulse_encoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Timing registers as the encoder should hold them.
	logic [TICK_W-1:0] cfg_period = SLOT_PERIOD_RST;
	logic [TICK_W-1:0] cfg_hi0 = HIGH_ZERO_RST;
	logic [TICK_W-1:0] cfg_hi1 = HIGH_ONE_RST;
	logic [RSLOT_W-1:0] cfg_latch = RESET_SLOTS_RST;

	// Frame state of the encoder as predicted here.
	logic [COLOR_W-1:0] want_color = '0;
	logic want_valid = 1'b0;
	word_t out_word = '0;
	logic [TICK_W-1:0] tick_cnt = '0;
	logic [SLOT_W-1:0] slot_idx = '0;
	logic in_frame = 1'b0;
	logic line_hold = 1'b0;

	line_out_t line_results_q [$];
	int err_count = 0;
	int cycle_count = 0;

	// Idle rates of both sides, in percent, and the one long receiver stall.
	int src_gap_pct = 14;
	int sink_gap_pct = 56;
	logic stall_armed = 1'b0;
	logic stall_done = 1'b0;
	int stall_left = 0;

	logic took_result = 1'b0;
	logic took_level;
	logic took_busy;

	step_row_t directed_steps [0:DIRECTED_ROWS-1] = '{
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_TIMING, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd1, 12'd0, 12'd4095, 8'd0},
		'{ROW_REQUEST, CMD_COLOR, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_COLOR, 24'h800001, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_COLOR, 24'h000000, 1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h123456, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_TIMING, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd1, 12'd0, 12'd4095, 8'd0},
		'{ROW_REQUEST, CMD_COLOR, 24'hA5A5A5, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_TIMING, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd4094, 12'd1, 8'd3},
		'{ROW_REQUEST, CMD_COLOR, 24'h5A5A5A, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_TIMING, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd3, 12'd3, 12'd2, 8'd1},
		'{ROW_REQUEST, CMD_COLOR, 24'h0F0F0F, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0},
		'{ROW_REQUEST, CMD_TICK, 24'h000000, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 8'd0}
	};

	// Advance the predicted encoder by one request and return the line and busy flag.
	function automatic line_out_t encode_request(cmd_t kind, logic [COLOR_W-1:0] rgb);
		line_out_t r;
		logic [TICK_W-1:0] high_ticks;
		logic level;
		logic busy;
		if (kind == CMD_COLOR) begin
			// A color request only replaces the waiting color; the line holds.
			want_color = rgb;
			want_valid = 1'b1;
			r.level = line_hold;
			r.busy = in_frame;
			return r;
		end
		// An idle encoder with a color waiting opens the frame on this tick.
		if (!in_frame && want_valid) begin
			out_word = word_t'(want_color);
			want_valid = 1'b0;
			in_frame = 1'b1;
			tick_cnt = '0;
			slot_idx = '0;
		end
		busy = in_frame;
		if (in_frame) begin
			level = 1'b0;
			if (slot_idx < COLOR_BITS) begin
				high_ticks = out_word[COLOR_BITS-1] ? cfg_hi1 : cfg_hi0;
				level = (tick_cnt < high_ticks);
			end
			line_hold = level;
			// Slot ends; a period of zero or one gives one-tick slots.
			if ({1'b0, tick_cnt} + 13'd1 >= {1'b0, cfg_period}) begin
				tick_cnt = '0;
				if (slot_idx < COLOR_BITS)
					out_word = out_word << 1;
				slot_idx = slot_idx + 1'b1;
				if (int'(slot_idx) >= COLOR_BITS + int'(cfg_latch)) begin
					in_frame = 1'b0;
					slot_idx = '0;
				end
			end else begin
				tick_cnt = tick_cnt + 1'b1;
			end
		end else begin
			line_hold = 1'b0;
		end
		r.level = line_hold;
		r.busy = busy;
		return r;
	endfunction

	// Offer one request, wait for it to be taken, and record its expected result.
	task automatic send_request(input cmd_t kind, input logic [COLOR_W-1:0] rgb,
			input logic typed, input line_out_t typed_val);
		line_out_t predicted;
		while ($urandom_range(0, 99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= kind;
		in_ch.color <= rgb;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		predicted = encode_request(kind, rgb);
		line_results_q.push_back(typed ? typed_val : predicted);
		@(negedge clk);
	endtask

	// Tick until the frame and any waiting color are done, then let results drain.
	task automatic settle_line();
		while (in_frame || want_valid)
			send_request(CMD_TICK, COLOR_W'($urandom), 1'b0, '0);
		in_ch.valid <= 1'b0;
		while (line_results_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 1) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		case (idx)
			REG_SLOT_PERIOD: cfg_period = data;
			REG_HIGH_ZERO: cfg_hi0 = data;
			REG_HIGH_ONE: cfg_hi1 = data;
			REG_RESET_SLOTS: cfg_latch = data[RSLOT_W-1:0];
			default: ;
		endcase
	endtask

	// The upper bits of the latch slot write are noise the register must drop.
	task automatic load_timing(input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] hi0,
			input logic [TICK_W-1:0] hi1, input logic [RSLOT_W-1:0] latch);
		write_reg(REG_SLOT_PERIOD, period);
		write_reg(REG_HIGH_ZERO, hi0);
		write_reg(REG_HIGH_ONE, hi1);
		write_reg(REG_RESET_SLOTS, {4'($urandom), latch});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Short frames with high times around the slot period.
	task automatic load_random_timing();
		logic [TICK_W-1:0] period;
		period = TICK_W'($urandom_range(2, 6));
		load_timing(period, TICK_W'($urandom_range(0, period + 1)),
			TICK_W'($urandom_range(0, period + 1)), RSLOT_W'($urandom_range(0, 3)));
	endtask

	// Mostly ticks, with a color request now and then to start or replace a frame.
	task automatic run_random(input int count, input int color_one_in);
		cmd_t kind;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(0, color_one_in - 1) == 0) ? CMD_COLOR : CMD_TICK;
			send_request(kind, COLOR_W'($urandom), 1'b0, '0);
		end
	endtask

	// Receiver: random idling, plus one long stall that fills the encoder.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (stall_armed && !stall_done) begin
			stall_left <= LONG_STALL;
			stall_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
		end
	end

	// Take each result at the rising edge; compare it on the falling edge.
	always @(posedge clk) begin
		took_result <= arst_n && out_ch.valid && out_ch.ready;
		took_level <= out_ch.line_level;
		took_busy <= out_ch.busy_res;
	end

	always @(negedge clk) begin
		line_out_t want;
		if (took_result) begin
			if (line_results_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: result with none expected: line_level %b busy_res %b",
						$time, took_level, took_busy);
			end else begin
				want = line_results_q.pop_front();
				if (took_level !== want.level) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: line_level expected %b, got %b",
							$time, want.level, took_level);
				end
				if (took_busy !== want.busy) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: busy_res expected %b, got %b",
							$time, want.busy, took_busy);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.color = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SLOT_PERIOD;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: the reset state, then one-tick slots and extreme high times.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_steps[i].kind == ROW_TIMING) begin
				settle_line();
				load_timing(directed_steps[i].period, directed_steps[i].hi_zero,
					directed_steps[i].hi_one, directed_steps[i].latch);
			end else begin
				send_request(directed_steps[i].cmd, directed_steps[i].color,
					directed_steps[i].known,
					'{directed_steps[i].exp_level, directed_steps[i].exp_busy});
			end
		end

		// Sender idles rarely, receiver often; the long stall falls here.
		settle_line();
		load_timing(12'd4, 12'd1, 12'd3, 8'd2);
		stall_armed <= 1'b1;
		run_random(150, 12);
		settle_line();
		load_random_timing();
		run_random(150, 10);

		// Sender idles often, receiver rarely.
		src_gap_pct <= 56;
		sink_gap_pct <= 14;
		settle_line();
		load_random_timing();
		run_random(100, 8);
		settle_line();
		load_timing(12'd2, 12'd1, 12'd1, 8'd0);
		run_random(100, 16);

		// No idling: the longest latch gap, then the longest slot.
		src_gap_pct <= 0;
		sink_gap_pct <= 0;
		settle_line();
		load_timing(12'd1, 12'd0, 12'd2, 8'd255);
		run_random(100, 20);
		settle_line();
		load_timing(12'd4095, 12'd4094, 12'd4095, 8'd0);
		run_random(50, 6);

		in_ch.valid <= 1'b0;
		while (line_results_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
